// File: src/mcbp_pkg.sv
// shared types, constants and command table of the management command byte parser
package mcbp_pkg;

  localparam int unsigned NUM_CMDS = 6;
  localparam int unsigned MAX_ARGS = 2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ARGS = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } parse_phase_t;

  typedef logic [2:0] cmd_code_t;
  typedef logic [1:0] arg_idx_t;

  // argument count per command, capped at MAX_ARGS
  function automatic arg_idx_t arg_count(input cmd_code_t cmd);
    logic [2:0] n;
    begin
      case (cmd)
        3'd1:    n = 3'd2;
        3'd2:    n = 3'd1;
        3'd4:    n = 3'd1;
        default: n = 3'd0;
      endcase
      if (n > 3'(MAX_ARGS)) begin
        n = 3'(MAX_ARGS);
      end
      arg_count = n[1:0];
    end
  endfunction

  // single byte argument, otherwise a string
  function automatic logic arg_is_byte_type(input cmd_code_t cmd, input arg_idx_t idx);
    begin
      arg_is_byte_type = (cmd == 3'd4) && (idx == 2'd0);
    end
  endfunction

endpackage

// File: src/mcbp_if.sv
// word channels of the management command byte parser
interface mcbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mcbp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase;
  logic [2:0] command_code;
  logic       invalid_flag;
  logic       arg_valid;
  logic       arg_number;
  logic       arg_is_byte;
  logic [7:0] arg_offset;
  logic [7:0] arg_value;
  logic       arg_last;

  modport source (
    output valid, output phase, output command_code, output invalid_flag,
    output arg_valid, output arg_number, output arg_is_byte, output arg_offset,
    output arg_value, output arg_last, input ready
  );
  modport sink (
    input valid, input phase, input command_code, input invalid_flag,
    input arg_valid, input arg_number, input arg_is_byte, input arg_offset,
    input arg_value, input arg_last, output ready
  );
endinterface

// File: src/mgmt_command_byte_parser_core.sv
// management command byte parser: input register, parse logic, result register
//
//   channel     dir   contents
//   byte_ch     in    data_byte, restart
//   result_ch   out   phase, command_code, invalid_flag, arg_* fields
//
// one word per cycle while the result is not stalled
// the parse state updates in the same cycle the result register loads
// rst clears the parse state and both valid flags
// a stalled result holds; the input register still takes one further word
module mgmt_command_byte_parser_core (
  input  logic      clk,
  input  logic      rst,
  mcbp_in_if.sink   byte_ch,
  mcbp_out_if.source result_ch
);
  import mcbp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_restart;

  // parse state
  parse_phase_t phase, phase_next;
  cmd_code_t    cmd, cmd_next;
  arg_idx_t     args_done, args_done_next;
  logic [7:0]   slen, slen_next;
  logic [7:0]   chars, chars_next;

  // result register
  logic       out_valid;
  logic       r_arg_valid, r_arg_number, r_arg_is_byte, r_arg_last;
  logic [7:0] r_arg_offset, r_arg_value;

  logic       a_valid, a_number, a_is_byte, a_last;
  logic [7:0] a_offset, a_value;

  logic out_free, s1_go;

  assign out_free      = !out_valid || result_ch.ready;
  assign s1_go         = s1_valid && out_free;
  assign byte_ch.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
    if (byte_ch.ready && byte_ch.valid) begin
      s1_byte    <= byte_ch.data_byte;
      s1_restart <= byte_ch.restart;
    end
  end

  always_comb begin
    parse_phase_t ph;
    cmd_code_t    c;
    arg_idx_t     ad;
    logic [7:0]   sl, ch, ch_inc;
    logic         finished;
    ph = s1_restart ? PH_WAIT : phase;
    c  = s1_restart ? 3'd0    : cmd;
    ad = s1_restart ? 2'd0    : args_done;
    sl = s1_restart ? 8'd0    : slen;
    ch = s1_restart ? 8'd0    : chars;
    ch_inc = ch + 8'd1;
    finished = 1'b0;

    phase_next     = ph;
    cmd_next       = c;
    args_done_next = ad;
    slen_next      = sl;
    chars_next     = ch;

    a_valid  = 1'b0;
    a_number = 1'b0;
    a_is_byte = 1'b0;
    a_offset = 8'd0;
    a_value  = 8'd0;
    a_last   = 1'b0;

    case (ph)
      PH_WAIT: begin
        if (s1_byte >= 8'(NUM_CMDS)) begin
          phase_next = PH_ERR;
        end else begin
          cmd_next       = s1_byte[2:0];
          phase_next     = (arg_count(s1_byte[2:0]) == 2'd0) ? PH_DONE : PH_ARGS;
          args_done_next = 2'd0;
          slen_next      = 8'd0;
          chars_next     = 8'd0;
        end
      end
      PH_ARGS: begin
        if (arg_is_byte_type(c, ad)) begin
          a_valid   = 1'b1;
          a_number  = ad[0];
          a_is_byte = 1'b1;
          a_value   = s1_byte;
          a_last    = 1'b1;
          finished  = 1'b1;
        end else if (sl == 8'd0) begin
          if (s1_byte == 8'd0) begin
            phase_next = PH_ERR;
          end else begin
            slen_next = s1_byte;
          end
        end else begin
          a_valid    = 1'b1;
          a_number   = ad[0];
          a_offset   = ch;
          a_value    = s1_byte;
          chars_next = ch_inc;
          if (ch_inc == sl) begin
            a_last   = 1'b1;
            finished = 1'b1;
          end
        end
        if (finished) begin
          args_done_next = ad + 2'd1;
          slen_next      = 8'd0;
          chars_next     = 8'd0;
          if (args_done_next >= arg_count(c)) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      cmd       <= 3'd0;
      args_done <= 2'd0;
      slen      <= 8'd0;
      chars     <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        phase     <= phase_next;
        cmd       <= cmd_next;
        args_done <= args_done_next;
        slen      <= slen_next;
        chars     <= chars_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_go) begin
      r_arg_valid   <= a_valid;
      r_arg_number  <= a_number;
      r_arg_is_byte <= a_is_byte;
      r_arg_offset  <= a_offset;
      r_arg_value   <= a_value;
      r_arg_last    <= a_last;
    end
  end

  // phase and code come straight from the updated state
  assign result_ch.valid        = out_valid;
  assign result_ch.phase        = phase;
  assign result_ch.command_code = cmd;
  assign result_ch.invalid_flag = (phase == PH_ERR);
  assign result_ch.arg_valid    = r_arg_valid;
  assign result_ch.arg_number   = r_arg_number;
  assign result_ch.arg_is_byte  = r_arg_is_byte;
  assign result_ch.arg_offset   = r_arg_offset;
  assign result_ch.arg_value    = r_arg_value;
  assign result_ch.arg_last     = r_arg_last;

endmodule

// File: src/mcbp_checker.sv
// port-level assertions for the management command byte parser, with bind
module mcbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] phase,
  input logic       invalid_flag,
  input logic       arg_valid,
  input logic       arg_number,
  input logic       arg_is_byte,
  input logic [7:0] arg_offset,
  input logic [7:0] arg_value,
  input logic       arg_last
);
  import mcbp_pkg::*;

  a_err_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (invalid_flag == (phase == PH_ERR)))
    else $error("invalid_flag disagrees with phase");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !arg_valid) |-> (!arg_number && !arg_is_byte && !arg_last &&
                                   arg_offset == 8'd0 && arg_value == 8'd0))
    else $error("argument fields set without payload");

  a_byte_arg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_valid && arg_is_byte) |-> (arg_last && arg_offset == 8'd0))
    else $error("single byte argument not marked last");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && arg_valid) |-> (phase == PH_ARGS || phase == PH_DONE))
    else $error("payload word outside argument parsing");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

endmodule

bind mgmt_command_byte_parser_core mcbp_checker u_mcbp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .phase        (result_ch.phase),
  .invalid_flag (result_ch.invalid_flag),
  .arg_valid    (result_ch.arg_valid),
  .arg_number   (result_ch.arg_number),
  .arg_is_byte  (result_ch.arg_is_byte),
  .arg_offset   (result_ch.arg_offset),
  .arg_value    (result_ch.arg_value),
  .arg_last     (result_ch.arg_last)
);
